// File: rtl/mssc_pkg.sv
`timescale 1ns / 1ps

package mssc_pkg;

  localparam int REG_WIDTH          = 16;
  localparam int CFG_INDEX_WIDTH    = 2;
  localparam int PERIOD_WIDTH_DEF   = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SECOND_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCAN_PERIOD   = 2'd1;

  localparam logic [REG_WIDTH-1:0] SECOND_PERIOD_RST = 16'd100;
  localparam logic [REG_WIDTH-1:0] SCAN_PERIOD_RST   = 16'd10;

  localparam logic [4:0] HOURS_RST   = 5'd15;
  localparam logic [5:0] MINUTES_RST = 6'd8;
  localparam logic [5:0] SECONDS_RST = 6'd50;

  localparam logic [5:0] SIXTY      = 6'd60;
  localparam logic [4:0] TWENTYFOUR = 5'd24;

  // Scan positions, left to right on the display
  localparam logic [1:0] POS_HOUR_TENS   = 2'd0;
  localparam logic [1:0] POS_HOUR_UNITS  = 2'd1;
  localparam logic [1:0] POS_MIN_TENS    = 2'd2;
  localparam logic [1:0] POS_MIN_UNITS   = 2'd3;

  localparam logic [6:0] SEG_ALL_OFF = 7'h7F;
  localparam logic [3:0] EN_ALL_OFF  = 4'hF;

  // Tens digit of a value below 64
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60)      t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else                 t = 4'd0;
    return t;
  endfunction

  // Units digit of a value below 64
  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [3:0] t;
    logic [6:0] tens_x10;
    logic [6:0] diff;
    t        = tens_of(v);
    tens_x10 = 7'({3'd0, t} * 7'd10);
    diff     = {1'b0, v} - tens_x10;
    return diff[3:0];
  endfunction

  // Active-low segment pattern, bit0 = a .. bit6 = g
  function automatic logic [6:0] seg_pattern(input logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'd0:    p = 7'h40;
      4'd1:    p = 7'h79;
      4'd2:    p = 7'h24;
      4'd3:    p = 7'h30;
      4'd4:    p = 7'h19;
      4'd5:    p = 7'h12;
      4'd6:    p = 7'h02;
      4'd7:    p = 7'h78;
      4'd8:    p = 7'h00;
      4'd9:    p = 7'h10;
      default: p = 7'h40;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/mssc_ifs.sv
`timescale 1ns / 1ps

interface mssc_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface mssc_disp_if;
  logic       valid;
  logic       ready;
  logic [6:0] seg_n;
  logic [3:0] digit_en_n;
  logic       dot;
  logic       red_led;
  logic [4:0] time_hour;
  logic [5:0] time_minute;
  logic [5:0] time_second;
  logic       second_pulse;

  modport source (output valid, output seg_n, output digit_en_n, output dot,
                  output red_led, output time_hour, output time_minute,
                  output time_second, output second_pulse, input ready);
  modport sink   (input valid, input seg_n, input digit_en_n, input dot,
                  input red_led, input time_hour, input time_minute,
                  input time_second, input second_pulse, output ready);
endinterface

// File: rtl/multiplexed_seven_segment_clock.sv
// Channel   Dir  Word                                         Handshake
// --------  ---  -------------------------------------------  ------------
// in_ch     in   tick                                         valid/ready
// out_ch    out  seg_n, digit_en_n, dot, red_led, time_hour,  valid/ready
//                time_minute, time_second, second_pulse
// cfg       in   cfg_index, cfg_data (second_period, scan_period)  cfg_we
//
// One word per clock while out_ch is not stalling: a tick word is taken,
// all counters and the time update in the same cycle, and the display
// word lands in the output register the next edge.
// The output register is the only buffer; in_ch.ready drops only while it
// holds a word that out_ch has not taken. rst (synchronous) restores the
// time 15:08:50, blanks the display and sets both periods to defaults.
`timescale 1ns / 1ps

module multiplexed_seven_segment_clock #(
  parameter int PERIOD_WIDTH = mssc_pkg::PERIOD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  mssc_tick_if.sink                            in_ch,
  mssc_disp_if.source                          out_ch,
  input  logic                                 cfg_we,
  input  logic [mssc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [mssc_pkg::REG_WIDTH-1:0]       cfg_data
);

  // Configuration
  logic [mssc_pkg::REG_WIDTH-1:0] second_period;
  logic [mssc_pkg::REG_WIDTH-1:0] scan_period;

  // Clock state
  logic [PERIOD_WIDTH-1:0] second_elapsed, second_elapsed_next;
  logic [PERIOD_WIDTH-1:0] scan_elapsed, scan_elapsed_next;
  logic [4:0]              hours_count, hours_count_next;
  logic [5:0]              minutes_count, minutes_count_next;
  logic [5:0]              seconds_count, seconds_count_next;
  logic [1:0]              scan_index, scan_index_next;
  logic [6:0]              segment_latch, segment_latch_next;
  logic [3:0]              enable_latch, enable_latch_next;
  logic                    dot_level, dot_level_next;
  logic                    red_level, red_level_next;

  // Output register
  logic       out_valid;
  logic [6:0] out_seg_n;
  logic [3:0] out_digit_en_n;
  logic       out_dot;
  logic       out_red_led;
  logic [4:0] out_hour;
  logic [5:0] out_minute;
  logic [5:0] out_second;
  logic       out_pulse;

  logic                    in_accept;
  logic                    tick;
  logic [PERIOD_WIDTH-1:0] sec_p, scan_p;
  logic [PERIOD_WIDTH-1:0] sec_inc, scan_inc;
  logic                    sec_exp, scan_exp;
  logic [5:0]              sec_add, min_add;
  logic [4:0]              hour_add;
  logic [3:0]              digit;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign tick        = in_ch.tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      second_period <= mssc_pkg::SECOND_PERIOD_RST;
      scan_period   <= mssc_pkg::SCAN_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mssc_pkg::REG_SECOND_PERIOD: second_period <= cfg_data;
        mssc_pkg::REG_SCAN_PERIOD:   scan_period   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Periods seen at counter width
  assign sec_p  = PERIOD_WIDTH'(second_period);
  assign scan_p = PERIOD_WIDTH'(scan_period);

  // Counters wrap at counter width; a wrap to zero also counts as expiry
  assign sec_inc  = second_elapsed + 1'b1;
  assign scan_inc = scan_elapsed + 1'b1;
  assign sec_exp  = tick && (sec_p != '0) && ((sec_inc >= sec_p) || (sec_inc == '0));
  assign scan_exp = tick && (scan_p != '0) && ((scan_inc >= scan_p) || (scan_inc == '0));

  always_comb begin
    second_elapsed_next = second_elapsed;
    if (tick && sec_p != '0) begin
      second_elapsed_next = sec_exp ? '0 : sec_inc;
    end
    scan_elapsed_next = scan_elapsed;
    if (tick && scan_p != '0) begin
      scan_elapsed_next = scan_exp ? '0 : scan_inc;
    end
  end

  // 24-hour time advance; the state always stays in range
  always_comb begin
    sec_add  = seconds_count + 6'd1;
    min_add  = minutes_count;
    hour_add = hours_count;
    if (sec_add >= mssc_pkg::SIXTY) begin
      sec_add = '0;
      min_add = minutes_count + 6'd1;
    end
    if (min_add >= mssc_pkg::SIXTY) begin
      min_add  = '0;
      hour_add = hours_count + 5'd1;
    end
    if (hour_add >= mssc_pkg::TWENTYFOUR) begin
      hour_add = '0;
    end

    seconds_count_next = sec_exp ? sec_add  : seconds_count;
    minutes_count_next = sec_exp ? min_add  : minutes_count;
    hours_count_next   = sec_exp ? hour_add : hours_count;
    dot_level_next     = dot_level ^ sec_exp;
    red_level_next     = red_level ^ sec_exp;
  end

  // Digit for the current scan position, taken from the updated time
  always_comb begin
    case (scan_index)
      mssc_pkg::POS_HOUR_TENS:  digit = mssc_pkg::tens_of({1'b0, hours_count_next});
      mssc_pkg::POS_HOUR_UNITS: digit = mssc_pkg::units_of({1'b0, hours_count_next});
      mssc_pkg::POS_MIN_TENS:   digit = mssc_pkg::tens_of(minutes_count_next);
      mssc_pkg::POS_MIN_UNITS:  digit = mssc_pkg::units_of(minutes_count_next);
      default:                  digit = '0;
    endcase
    segment_latch_next = scan_exp ? mssc_pkg::seg_pattern(digit) : segment_latch;
    enable_latch_next  = scan_exp ? ~(4'b0001 << scan_index) : enable_latch;
    scan_index_next    = scan_exp ? scan_index + 2'd1 : scan_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_elapsed <= '0;
      scan_elapsed   <= '0;
      hours_count    <= mssc_pkg::HOURS_RST;
      minutes_count  <= mssc_pkg::MINUTES_RST;
      seconds_count  <= mssc_pkg::SECONDS_RST;
      scan_index     <= '0;
      segment_latch  <= mssc_pkg::SEG_ALL_OFF;
      enable_latch   <= mssc_pkg::EN_ALL_OFF;
      dot_level      <= 1'b1;
      red_level      <= 1'b1;
    end else if (in_accept) begin
      second_elapsed <= second_elapsed_next;
      scan_elapsed   <= scan_elapsed_next;
      hours_count    <= hours_count_next;
      minutes_count  <= minutes_count_next;
      seconds_count  <= seconds_count_next;
      scan_index     <= scan_index_next;
      segment_latch  <= segment_latch_next;
      enable_latch   <= enable_latch_next;
      dot_level      <= dot_level_next;
      red_level      <= red_level_next;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_seg_n      <= segment_latch_next;
      out_digit_en_n <= enable_latch_next;
      out_dot        <= dot_level_next;
      out_red_led    <= red_level_next;
      out_hour       <= hours_count_next;
      out_minute     <= minutes_count_next;
      out_second     <= seconds_count_next;
      out_pulse      <= sec_exp;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.seg_n        = out_seg_n;
  assign out_ch.digit_en_n   = out_digit_en_n;
  assign out_ch.dot          = out_dot;
  assign out_ch.red_led      = out_red_led;
  assign out_ch.time_hour    = out_hour;
  assign out_ch.time_minute  = out_minute;
  assign out_ch.time_second  = out_second;
  assign out_ch.second_pulse = out_pulse;

  // At most one digit enabled, or all blanked
  a_one_digit: assert property (@(posedge clk) disable iff (rst)
    (enable_latch == mssc_pkg::EN_ALL_OFF) || $onehot(~enable_latch))
    else $error("more than one digit enabled");

  // Time stays a valid 24-hour value
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (hours_count < mssc_pkg::TWENTYFOUR) && (minutes_count < mssc_pkg::SIXTY) &&
    (seconds_count < mssc_pkg::SIXTY))
    else $error("time out of range");

  // A second expiry toggles the dot and reports a pulse
  a_sec_toggle: assert property (@(posedge clk) disable iff (rst)
    (in_accept && sec_exp) |=> (dot_level != $past(dot_level)) && out_pulse)
    else $error("second expiry did not toggle dot");

  // Without an accepted word the clock state holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> $stable(seconds_count) && $stable(scan_index) &&
                   $stable(second_elapsed) && $stable(scan_elapsed))
    else $error("state changed without an accepted word");

  // A full, stalled output register blocks input
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken over a pending output word");

endmodule
